[rtl/core/erg_pkg.sv]
// Package for the euclidean rhythm generator.
// Holds payload structs, controller/datapath command and status types, codes.
// No dependencies.
package erg_pkg;

    localparam int MAX_STEPS_DEF = 64;

    localparam logic [1:0] ACC_MUTE = 2'd0;
    localparam logic [1:0] ACC_HIT  = 2'd1;
    localparam logic [1:0] ACC_DOWN = 2'd2;

    typedef struct packed {
        logic [6:0] pulses;
        logic [6:0] steps;
        logic       mark_downbeat;
    } t_req;

    typedef struct packed {
        logic [1:0] accent;
        logic [5:0] step_index;
        logic       last_step;
    } t_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GROUP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic group;
        logic emit_init;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic in_empty;
        logic grp_done;
        logic emit_last;
    } t_sts;

endpackage

[rtl/core/erg_ctrl.sv]
// Controller state machine of the euclidean rhythm generator.
// Sequences load, grouping rounds and step emission. Depends on erg_pkg.
module erg_ctrl import erg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start && !i_sts.in_empty) n_state = ST_GROUP;
            end
            ST_GROUP: begin
                if (i_sts.grp_done) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.emit_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start && !i_sts.in_empty;
            end
            ST_GROUP: begin
                o_cmd.group     = !i_sts.grp_done;
                o_cmd.emit_init = i_sts.grp_done;
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
            end
            default: o_busy = 1'b0;
        endcase
    end

endmodule

[rtl/core/erg_dp.sv]
// Datapath of the euclidean rhythm generator: pattern pair, lengths, copy
// counts, emission walk and registered result. Depends on erg_pkg.
module erg_dp import erg_pkg::*; #(
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_req i_req,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output t_rsp o_rsp,
    output logic o_strobe
);

    localparam int W  = MAX_STEPS;
    localparam int CW = $clog2(MAX_STEPS + 1);
    localparam int BW = $clog2(MAX_STEPS);

    logic [W-1:0]  r_pat_a, r_pat_b;
    logic [CW-1:0] r_len_a, r_len_b, r_ca, r_cb;
    logic [CW-1:0] r_pos, r_total, r_copy;
    logic [BW-1:0] r_bit;
    logic          r_pend, r_db, r_grp, r_phase_b;
    t_rsp          r_rsp;
    logic          r_vld;

    logic [6:0]    steps_c7, pulses_c7;
    logic [CW-1:0] steps_c, pulses_c, pairs;
    logic [W-1:0]  cur_pat;
    logic [CW-1:0] cur_len, cur_cnt;
    logic          hit, bit_end, copy_end, is_last;

    always_comb begin
        steps_c7  = (i_req.steps > 7'(MAX_STEPS)) ? 7'(MAX_STEPS) : i_req.steps;
        pulses_c7 = (i_req.pulses > steps_c7) ? steps_c7 : i_req.pulses;
        steps_c   = CW'(steps_c7);
        pulses_c  = CW'(pulses_c7);
        pairs     = (r_ca < r_cb) ? r_ca : r_cb;
        cur_pat   = r_phase_b ? r_pat_b : r_pat_a;
        cur_len   = r_phase_b ? r_len_b : r_len_a;
        cur_cnt   = r_phase_b ? r_cb : r_ca;
        hit       = cur_pat[r_bit];
        bit_end   = (CW'(r_bit) + CW'(1)) == cur_len;
        copy_end  = (r_copy + CW'(1)) == cur_cnt;
        is_last   = (r_pos + CW'(1)) == r_total;
    end

    assign o_sts.in_empty  = (i_req.steps == 7'd0);
    assign o_sts.grp_done  = !(r_grp && (r_cb > CW'(1)));
    assign o_sts.emit_last = is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_a   <= '0;
            r_pat_b   <= '0;
            r_len_a   <= '0;
            r_len_b   <= '0;
            r_ca      <= '0;
            r_cb      <= '0;
            r_pos     <= '0;
            r_total   <= '0;
            r_copy    <= '0;
            r_bit     <= '0;
            r_pend    <= 1'b1;
            r_db      <= 1'b0;
            r_grp     <= 1'b0;
            r_phase_b <= 1'b0;
            r_rsp     <= '0;
            r_vld     <= 1'b0;
        end else begin
            r_vld <= i_cmd.emit;
            if (i_cmd.load) begin
                r_pat_a <= W'(1);
                r_len_a <= CW'(1);
                r_ca    <= pulses_c;
                r_pat_b <= '0;
                r_len_b <= CW'(1);
                r_cb    <= steps_c - pulses_c;
                r_pos   <= '0;
                r_pend  <= 1'b1;
                r_db    <= i_req.mark_downbeat;
                r_total <= steps_c;
                r_grp   <= (pulses_c != '0) && (pulses_c < steps_c);
            end
            if (i_cmd.group) begin
                r_pat_a <= r_pat_a | (r_pat_b << r_len_a);
                r_len_a <= r_len_a + r_len_b;
                r_ca    <= pairs;
                if (r_ca <= r_cb) begin
                    r_cb <= r_cb - r_ca;
                end else begin
                    r_cb    <= r_ca - r_cb;
                    r_pat_b <= r_pat_a;
                    r_len_b <= r_len_a;
                end
            end
            if (i_cmd.emit_init) begin
                r_phase_b <= (r_ca == '0);
                r_bit     <= '0;
                r_copy    <= '0;
            end
            if (i_cmd.emit) begin
                r_rsp.accent     <= hit ? ((r_pend && r_db) ? ACC_DOWN : ACC_HIT) : ACC_MUTE;
                r_rsp.step_index <= 6'(r_pos);
                r_rsp.last_step  <= is_last;
                if (hit) r_pend <= 1'b0;
                r_pos <= r_pos + CW'(1);
                if (bit_end) begin
                    r_bit <= '0;
                    if (copy_end) begin
                        r_phase_b <= 1'b1;
                        r_copy    <= '0;
                    end else begin
                        r_copy <= r_copy + CW'(1);
                    end
                end else begin
                    r_bit <= r_bit + BW'(1);
                end
            end
        end
    end

    assign o_rsp    = r_rsp;
    assign o_strobe = r_vld;

    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_pos < r_total))
        else $error("emit past rhythm length");

    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_pos == '0) && r_pend)
        else $error("load did not restart emission");

    a_group_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.group |=> (r_len_a <= r_total))
        else $error("pattern grew past step count");

    a_single_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && (r_rsp.accent == ACC_DOWN)) |-> !r_pend)
        else $error("downbeat left pending");

endmodule

[rtl/core/euclidean_rhythm_generator.sv]
// Euclidean rhythm generator, top level: erg_ctrl sequences erg_dp.
// Sequence: accept, R grouping rounds (one per cycle), a setup step, then
// one step per cycle; each result passes the state and result registers.
// Busy through grouping, setup and emission; steps of zero is never accepted.
// Results are strobed once per step and cannot be stalled.
// Reset: synchronous, active low, returns the controller to idle.
module euclidean_rhythm_generator import erg_pkg::*; #(
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output t_rsp o_rsp,
    output logic o_strobe
);

    t_cmd cmd;
    t_sts sts;

    erg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    erg_dp #(
        .MAX_STEPS (MAX_STEPS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_rsp    (o_rsp),
        .o_strobe (o_strobe)
    );

endmodule
